>>> rtl/ipmsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmsh_pkg
// Shared types and constants for the address middle-square hash pipeline.
// ----------------------------------------------------------------------------
package ipmsh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HASH_W  = 64;
    localparam int unsigned NUM_RND = 4;

    localparam logic [NUM_RND-1:0][HASH_W-1:0] ROUND_CONST = {
        64'h082EFA98EC4E6C89,
        64'hA4093822299F31D0,
        64'h13198A2E03707344,
        64'h243F6A8885A308D3
    };

    typedef logic [NUM_RND-1:0][WORD_W-1:0] words_t;

    typedef struct packed {
        words_t            words;
        logic [HASH_W-1:0] hash;
    } item_t;

    // x + (x << 16) + (x << 32), modulo 2^64
    function automatic logic [HASH_W-1:0] spread(input logic [WORD_W-1:0] x);
        return {x, x} + {16'd0, x, 16'd0};
    endfunction

endpackage
`default_nettype wire

>>> rtl/ipmsh_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmsh_round
// One middle-square round in three stages: add spread word and constant,
// 32x32 partial products, recombine and keep bits 95..32 of the square.
// ----------------------------------------------------------------------------
module ipmsh_round (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [1:0]         round_idx,
    input  wire logic               in_valid,
    input  wire ipmsh_pkg::item_t   in_item,
    output logic                    in_ready,
    output logic                    out_valid,
    output ipmsh_pkg::item_t        out_item,
    input  wire logic               out_ready
);

    logic                    valid_a_reg, valid_b_reg, valid_c_reg;
    logic                    ready_a, ready_b, ready_c;
    ipmsh_pkg::words_t       words_a_reg, words_b_reg;
    logic [63:0]             sum_a_reg, sum_a_next;
    logic [63:0]             aa_reg, ab_reg, bb_reg;
    ipmsh_pkg::item_t        item_c_reg;
    logic [128:0]            square;

    assign ready_c  = !valid_c_reg || out_ready;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign sum_a_next = in_item.hash + ipmsh_pkg::ROUND_CONST[round_idx]
                      + ipmsh_pkg::spread(in_item.words[round_idx]);

    assign square = {1'b0, bb_reg, aa_reg} + {32'd0, ab_reg, 33'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else begin
            if (ready_a) valid_a_reg <= in_valid;
            if (ready_b) valid_b_reg <= valid_a_reg;
            if (ready_c) valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a) begin
            words_a_reg <= in_item.words;
            sum_a_reg   <= sum_a_next;
        end
        if (ready_b) begin
            words_b_reg <= words_a_reg;
            aa_reg      <= sum_a_reg[31:0]  * sum_a_reg[31:0];
            ab_reg      <= sum_a_reg[31:0]  * sum_a_reg[63:32];
            bb_reg      <= sum_a_reg[63:32] * sum_a_reg[63:32];
        end
        if (ready_c) begin
            item_c_reg.words <= words_b_reg;
            item_c_reg.hash  <= square[95:32];
        end
    end

    assign out_valid = valid_c_reg;
    assign out_item  = item_c_reg;

endmodule
`default_nettype wire

>>> rtl/ip_address_middle_square_hash_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_address_middle_square_hash_core
// Stateless 64-bit hash of a 128-bit address, prefix length and optional
// IPv4 host mask, built as a fully pipelined chain of middle-square rounds.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock unless stalled, and returns one hash per
// transaction, in order, through one stage for host masking and the seed,
// then three stages for each of the four rounds (add, 32x32 partial
// products, recombine). Each stage holds its item under back-pressure and
// fills when empty, so bubbles close up while the result channel stalls.
module ip_address_middle_square_hash_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_addr_word_0,
    input  wire logic [31:0] s_addr_word_1,
    input  wire logic [31:0] s_addr_word_2,
    input  wire logic [31:0] s_addr_word_3,
    input  wire logic [7:0]  s_prefix_length,
    input  wire logic [5:0]  s_mask_length,
    input  wire logic        s_mode,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_hash_value
);

    logic [5:0]              mask_sat;
    logic [5:0]              host_bits;
    logic [31:0]             word3_masked;
    logic                    valid_s_reg;
    ipmsh_pkg::item_t        item_s_reg, item_s_next;

    logic             rnd_valid [0:4];
    logic             rnd_ready [0:4];
    ipmsh_pkg::item_t rnd_item  [0:4];

    assign mask_sat  = (s_mask_length > 6'd32) ? 6'd32 : s_mask_length;
    assign host_bits = 6'd32 - mask_sat;

    // host bits clear whole bytes from the top, then the low bits of the next
    always_comb begin
        int rem;
        word3_masked = s_addr_word_3;
        for (int k = 0; k < 4; k++) begin
            rem = int'(host_bits) - 8 * (3 - k);
            if (s_mode) begin
                if (rem >= 8) begin
                    word3_masked[8*k +: 8] = 8'h00;
                end else if (rem > 0) begin
                    word3_masked[8*k +: 8] = s_addr_word_3[8*k +: 8]
                                           & 8'(8'hFF << rem[2:0]);
                end
            end
        end
    end

    always_comb begin
        item_s_next.words[0] = s_addr_word_0;
        item_s_next.words[1] = s_addr_word_1;
        item_s_next.words[2] = s_addr_word_2;
        item_s_next.words[3] = word3_masked;
        item_s_next.hash     = ipmsh_pkg::spread(word3_masked)
                             + ipmsh_pkg::spread({24'd0, s_prefix_length});
    end

    assign s_ready = !valid_s_reg || rnd_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_s_reg <= 1'b0;
        end else if (s_ready) begin
            valid_s_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            item_s_reg <= item_s_next;
        end
    end

    assign rnd_valid[0] = valid_s_reg;
    assign rnd_item[0]  = item_s_reg;

    for (genvar r = 0; r < 4; r++) begin : g_round
        ipmsh_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .round_idx (2'(r)),
            .in_valid  (rnd_valid[r]),
            .in_item   (rnd_item[r]),
            .in_ready  (rnd_ready[r]),
            .out_valid (rnd_valid[r+1]),
            .out_item  (rnd_item[r+1]),
            .out_ready (rnd_ready[r+1])
        );
    end

    assign rnd_ready[4]  = m_ready;
    assign m_valid       = rnd_valid[4];
    assign m_hash_value  = rnd_item[4].hash;

endmodule
`default_nettype wire
